FILE: hw/rtl/acm_pkg.sv
package acm_pkg;

	localparam int ALT_W      = 16;
	localparam int FRAC_W     = 16;
	localparam int COL_W      = 8;
	localparam int FRAC_SHIFT = 15;

	// bounds and scaled altitude, Q8.23 in a signed word
	localparam int Y_W   = 32;
	localparam int DY_W  = Y_W + 1;
	localparam int DC_W  = COL_W + 1;
	localparam int NUM_W = DY_W + DC_W;

	// divider widths
	localparam int UA_W  = NUM_W - 1;
	localparam int UB_W  = DY_W;
	localparam int Q_W   = COL_W + 1;
	localparam int D_W   = UB_W + 1;
	localparam int REM_W = D_W + Q_W;

	// configuration register indexes
	localparam int IDX_W = 3;
	localparam logic [IDX_W-1:0] REG_MODE       = 3'd0;
	localparam logic [IDX_W-1:0] REG_MIN_ALT    = 3'd1;
	localparam logic [IDX_W-1:0] REG_MAX_ALT    = 3'd2;
	localparam logic [IDX_W-1:0] REG_SEA_FRAC   = 3'd3;
	localparam logic [IDX_W-1:0] REG_LAND_FRAC  = 3'd4;
	localparam logic [IDX_W-1:0] REG_MOUNT_FRAC = 3'd5;
	localparam logic [IDX_W-1:0] REG_SNOW_FRAC  = 3'd6;

	localparam logic MODE_GRAY  = 1'b0;
	localparam logic MODE_EARTH = 1'b1;

	typedef struct packed {
		logic [COL_W-1:0] red;
		logic [COL_W-1:0] green;
		logic [COL_W-1:0] blue;
	} rgb_t;

	localparam rgb_t COL_BLACK = '{red: 8'd0,   green: 8'd0,   blue: 8'd0};
	localparam rgb_t COL_WHITE = '{red: 8'd255, green: 8'd255, blue: 8'd255};
	localparam rgb_t COL_DBLUE = '{red: 8'd0,   green: 8'd0,   blue: 8'd255};
	localparam rgb_t COL_GREEN = '{red: 8'd77,  green: 8'd255, blue: 8'd77};
	localparam rgb_t COL_BROWN = '{red: 8'd128, green: 8'd69,  blue: 8'd28};
	localparam rgb_t COL_GRAY  = '{red: 8'd128, green: 8'd128, blue: 8'd128};

	typedef struct packed {
		logic                    mode;
		logic signed [ALT_W-1:0] min_alt;
		logic signed [ALT_W-1:0] max_alt;
		logic [FRAC_W-1:0]       sea_frac;
		logic [FRAC_W-1:0]       land_frac;
		logic [FRAC_W-1:0]       mount_frac;
		logic [FRAC_W-1:0]       snow_frac;
	} cfg_t;

	// one interpolation job: start color, denominator, per-channel numerators
	typedef struct packed {
		logic                    valid;
		rgb_t                    start;
		logic signed [DY_W-1:0]  den;
		logic signed [NUM_W-1:0] num_r;
		logic signed [NUM_W-1:0] num_g;
		logic signed [NUM_W-1:0] num_b;
	} lerp_t;

endpackage

FILE: hw/rtl/altitude_color_mapper_unit.sv
// Maps one signed Q8.8 altitude to an 8-bit RGB color, either as a gray ramp
// from min_altitude to max_altitude or as an earth colormap (dark blue sea,
// then green-brown, brown-gray and gray-white segments, white on top) with
// bounds set by Q1.15 fractions of the altitude limits. One item is taken every
// cycle; each result passes the 3-stage segment front end and then the 13-stage
// rounding divider, which resolves the 9 quotient bits one at a time for all
// three channels. The whole pipeline holds while a result waits on rgb_ready.
// Configuration writes are taken every cycle and belong to periods with no
// item in flight; the user must keep to this, as the block does not enforce it.
module altitude_color_mapper_unit (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [acm_pkg::IDX_W-1:0]        cfg_index,
	input  logic [acm_pkg::FRAC_W-1:0]       cfg_data,
	input  logic                             alt_valid,
	output logic                             alt_ready,
	input  logic signed [acm_pkg::ALT_W-1:0] altitude,
	output logic                             rgb_valid,
	input  logic                             rgb_ready,
	output logic [acm_pkg::COL_W-1:0]        red,
	output logic [acm_pkg::COL_W-1:0]        green,
	output logic [acm_pkg::COL_W-1:0]        blue
);

	acm_pkg::cfg_t  cfg;
	acm_pkg::lerp_t lerp;
	acm_pkg::rgb_t  color;
	logic           en;

	// every stage advances unless the output holds an untaken result
	assign en        = !rgb_valid || rgb_ready;
	assign alt_ready = en;
	assign cfg_ready = 1'b1;

	acm_cfg u_cfg (
		.clk    (clk),
		.arst_n (arst_n),
		.wr_en  (cfg_valid && cfg_ready),
		.index  (cfg_index),
		.data   (cfg_data),
		.cfg    (cfg)
	);

	acm_segment u_segment (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_valid (alt_valid),
		.altitude (altitude),
		.cfg      (cfg),
		.lerp_out (lerp)
	);

	acm_rdiv u_rdiv (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en),
		.lerp_in (lerp),
		.valid   (rgb_valid),
		.color   (color)
	);

	assign red   = color.red;
	assign green = color.green;
	assign blue  = color.blue;

endmodule

FILE: hw/rtl/acm_cfg.sv
module acm_cfg (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         wr_en,
	input  logic [acm_pkg::IDX_W-1:0]    index,
	input  logic [acm_pkg::FRAC_W-1:0]   data,
	output acm_pkg::cfg_t                cfg
);

	acm_pkg::cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.mode       <= acm_pkg::MODE_GRAY;
			cfg_q.min_alt    <= -16'sd256;
			cfg_q.max_alt    <= 16'sd256;
			cfg_q.sea_frac   <= 16'd0;
			cfg_q.land_frac  <= 16'd9830;
			cfg_q.mount_frac <= 16'd22938;
			cfg_q.snow_frac  <= 16'd32768;
		end else if (wr_en) begin
			unique case (index)
				acm_pkg::REG_MODE:       cfg_q.mode       <= data[0];
				acm_pkg::REG_MIN_ALT:    cfg_q.min_alt    <= data;
				acm_pkg::REG_MAX_ALT:    cfg_q.max_alt    <= data;
				acm_pkg::REG_SEA_FRAC:   cfg_q.sea_frac   <= data;
				acm_pkg::REG_LAND_FRAC:  cfg_q.land_frac  <= data;
				acm_pkg::REG_MOUNT_FRAC: cfg_q.mount_frac <= data;
				acm_pkg::REG_SNOW_FRAC:  cfg_q.snow_frac  <= data;
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

FILE: hw/rtl/acm_segment.sv
module acm_segment (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             en,
	input  logic                             in_valid,
	input  logic signed [acm_pkg::ALT_W-1:0] altitude,
	input  acm_pkg::cfg_t                    cfg,
	output acm_pkg::lerp_t                   lerp_out
);

	localparam int PROD_W = acm_pkg::FRAC_W + acm_pkg::ALT_W + 1;

	function automatic logic signed [acm_pkg::Y_W-1:0] scale_alt(
		input logic signed [acm_pkg::ALT_W-1:0] a
	);
		return {{(acm_pkg::Y_W - acm_pkg::ALT_W - acm_pkg::FRAC_SHIFT){a[acm_pkg::ALT_W-1]}},
			a, {acm_pkg::FRAC_SHIFT{1'b0}}};
	endfunction

	// stage 1: bound products and scaled altitude
	logic signed [PROD_W-1:0] sea_p, land_p, mount_p, snow_p;

	assign sea_p   = $signed({1'b0, cfg.sea_frac})   * cfg.min_alt;
	assign land_p  = $signed({1'b0, cfg.land_frac})  * cfg.max_alt;
	assign mount_p = $signed({1'b0, cfg.mount_frac}) * cfg.max_alt;
	assign snow_p  = $signed({1'b0, cfg.snow_frac})  * cfg.max_alt;

	logic                           valid_s1;
	logic                           mode_s1;
	logic signed [acm_pkg::Y_W-1:0] y_s1, sea_s1, land_s1, mount_s1, snow_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (en) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			mode_s1  <= cfg.mode;
			y_s1     <= scale_alt(altitude);
			sea_s1   <= sea_p[acm_pkg::Y_W-1:0];
			land_s1  <= land_p[acm_pkg::Y_W-1:0];
			mount_s1 <= mount_p[acm_pkg::Y_W-1:0];
			snow_s1  <= snow_p[acm_pkg::Y_W-1:0];
		end
	end

	// stage 2: segment select, offsets and color deltas
	logic signed [acm_pkg::Y_W-1:0]  y1, y2;
	acm_pkg::rgb_t                   c1, c2;
	logic signed [acm_pkg::DY_W-1:0] dy_c, den_c;

	always_comb begin
		// flat segments keep y1 == y2 == y so both offsets are zero
		y1 = y_s1;
		y2 = y_s1;
		c1 = acm_pkg::COL_WHITE;
		c2 = acm_pkg::COL_WHITE;
		priority if (mode_s1 == acm_pkg::MODE_GRAY) begin
			y1 = scale_alt(cfg.min_alt);
			y2 = scale_alt(cfg.max_alt);
			c1 = acm_pkg::COL_BLACK;
			c2 = acm_pkg::COL_WHITE;
		end else if (y_s1 < sea_s1) begin
			c1 = acm_pkg::COL_DBLUE;
			c2 = acm_pkg::COL_DBLUE;
		end else if (y_s1 < land_s1) begin
			y1 = sea_s1;
			y2 = land_s1;
			c1 = acm_pkg::COL_GREEN;
			c2 = acm_pkg::COL_BROWN;
		end else if (y_s1 < mount_s1) begin
			y1 = land_s1;
			y2 = mount_s1;
			c1 = acm_pkg::COL_BROWN;
			c2 = acm_pkg::COL_GRAY;
		end else if (y_s1 < snow_s1) begin
			y1 = mount_s1;
			y2 = snow_s1;
			c1 = acm_pkg::COL_GRAY;
			c2 = acm_pkg::COL_WHITE;
		end else begin
			c1 = acm_pkg::COL_WHITE;
			c2 = acm_pkg::COL_WHITE;
		end
		dy_c  = $signed({y_s1[acm_pkg::Y_W-1], y_s1}) - $signed({y1[acm_pkg::Y_W-1], y1});
		den_c = $signed({y2[acm_pkg::Y_W-1], y2}) - $signed({y1[acm_pkg::Y_W-1], y1});
	end

	logic                            valid_s2;
	acm_pkg::rgb_t                   c1_s2;
	logic signed [acm_pkg::DC_W-1:0] dc_r_s2, dc_g_s2, dc_b_s2;
	logic signed [acm_pkg::DY_W-1:0] dy_s2, den_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (en) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			c1_s2   <= c1;
			dc_r_s2 <= $signed({1'b0, c2.red})   - $signed({1'b0, c1.red});
			dc_g_s2 <= $signed({1'b0, c2.green}) - $signed({1'b0, c1.green});
			dc_b_s2 <= $signed({1'b0, c2.blue})  - $signed({1'b0, c1.blue});
			dy_s2   <= dy_c;
			den_s2  <= den_c;
		end
	end

	// stage 3: numerators
	logic                             valid_s3;
	acm_pkg::rgb_t                    c1_s3;
	logic signed [acm_pkg::DY_W-1:0]  den_s3;
	logic signed [acm_pkg::NUM_W-1:0] num_r_s3, num_g_s3, num_b_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else if (en) begin
			valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			c1_s3    <= c1_s2;
			den_s3   <= den_s2;
			num_r_s3 <= dc_r_s2 * dy_s2;
			num_g_s3 <= dc_g_s2 * dy_s2;
			num_b_s3 <= dc_b_s2 * dy_s2;
		end
	end

	assign lerp_out = '{valid: valid_s3, start: c1_s3, den: den_s3,
		num_r: num_r_s3, num_g: num_g_s3, num_b: num_b_s3};

	// sea is the only region that starts dark blue, and it is flat
	a_sea_flat: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && c1_s2 == acm_pkg::COL_DBLUE |-> den_s2 == '0 && dy_s2 == '0)
		else $error("sea region reached the divider with a nonzero offset");

endmodule

FILE: hw/rtl/acm_rdiv.sv
module acm_rdiv (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           en,
	input  acm_pkg::lerp_t lerp_in,
	output logic           valid,
	output acm_pkg::rgb_t  color
);

	localparam int NCH   = 3;
	localparam int SUM_W = acm_pkg::COL_W + 3;
	localparam int NUM_W = acm_pkg::NUM_W;
	localparam int UA_W  = acm_pkg::UA_W;
	localparam int UB_W  = acm_pkg::UB_W;
	localparam int D_W   = acm_pkg::D_W;
	localparam int REM_W = acm_pkg::REM_W;
	localparam int Q_W   = acm_pkg::Q_W;
	localparam int COL_W = acm_pkg::COL_W;
	localparam logic [COL_W-1:0] COL_MAX = '1;

	logic signed [NUM_W-1:0] num_c   [NCH];
	logic [COL_W-1:0]        start_c [NCH];
	logic [UB_W-1:0]         ub_c;

	assign num_c[0]   = lerp_in.num_r;
	assign num_c[1]   = lerp_in.num_g;
	assign num_c[2]   = lerp_in.num_b;
	assign start_c[0] = lerp_in.start.red;
	assign start_c[1] = lerp_in.start.green;
	assign start_c[2] = lerp_in.start.blue;
	assign ub_c = lerp_in.den[acm_pkg::DY_W-1] ? UB_W'(-lerp_in.den) : UB_W'(lerp_in.den);

	// stage 1: magnitudes and result sign
	logic             valid_s1, zero_s1;
	logic [UB_W-1:0]  ub_s1;
	logic [UA_W-1:0]  ua_s1    [NCH];
	logic             neg_s1   [NCH];
	logic [COL_W-1:0] start_s1 [NCH];

	// stage 2: rounded dividend 2|a|+|b| and divisor 2|b|
	logic              valid_s2, zero_s2;
	logic [D_W-1:0]    d_s2;
	logic [REM_W-1:0]  n_s2     [NCH];
	logic              neg_s2   [NCH];
	logic [COL_W-1:0]  start_s2 [NCH];

	// quotient pipeline: index 0 is stage 3 (overflow check), each later index
	// has resolved one more quotient bit, most significant first
	logic [Q_W:0]      valid_s;
	logic              zero_s  [0:Q_W];
	logic [D_W-1:0]    d_s     [0:Q_W];
	logic [REM_W-1:0]  rem_s   [0:Q_W][0:NCH-1];
	logic [Q_W-1:0]    quo_s   [0:Q_W][0:NCH-1];
	logic              ovf_s   [0:Q_W][0:NCH-1];
	logic              neg_s   [0:Q_W][0:NCH-1];
	logic [COL_W-1:0]  start_s [0:Q_W][0:NCH-1];

	// final stage: signed add to the start color and clamp
	logic              valid_s13;
	acm_pkg::rgb_t     color_s13;

	logic [REM_W-1:0]  rem_nx [0:Q_W-1][0:NCH-1];
	logic [Q_W-1:0]    quo_nx [0:Q_W-1][0:NCH-1];
	logic [COL_W-1:0]  col_nx [NCH];

	always_comb begin
		logic [REM_W-1:0] dsh;
		logic             take;
		for (int j = 0; j < Q_W; j++) begin
			for (int ch = 0; ch < NCH; ch++) begin
				dsh  = REM_W'(d_s[j]) << (Q_W - 1 - j);
				take = rem_s[j][ch] >= dsh;
				rem_nx[j][ch] = take ? rem_s[j][ch] - dsh : rem_s[j][ch];
				quo_nx[j][ch] = {quo_s[j][ch][Q_W-2:0], take};
			end
		end
	end

	always_comb begin
		logic [Q_W-1:0]          qq;
		logic signed [SUM_W-1:0] sum;
		for (int ch = 0; ch < NCH; ch++) begin
			// a huge quotient saturates the same as the largest one kept
			priority if (zero_s[Q_W]) begin
				qq = '0;
			end else if (ovf_s[Q_W][ch]) begin
				qq = '1;
			end else begin
				qq = quo_s[Q_W][ch];
			end
			if (neg_s[Q_W][ch]) begin
				sum = $signed(SUM_W'(start_s[Q_W][ch])) - $signed(SUM_W'(qq));
			end else begin
				sum = $signed(SUM_W'(start_s[Q_W][ch])) + $signed(SUM_W'(qq));
			end
			priority if (sum < 0) begin
				col_nx[ch] = '0;
			end else if (sum > $signed(SUM_W'(COL_MAX))) begin
				col_nx[ch] = COL_MAX;
			end else begin
				col_nx[ch] = sum[COL_W-1:0];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1  <= 1'b0;
			valid_s2  <= 1'b0;
			valid_s   <= '0;
			valid_s13 <= 1'b0;
		end else if (en) begin
			valid_s1   <= lerp_in.valid;
			valid_s2   <= valid_s1;
			valid_s[0] <= valid_s2;
			for (int j = 0; j < Q_W; j++) begin
				valid_s[j+1] <= valid_s[j];
			end
			valid_s13 <= valid_s[Q_W];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			zero_s1 <= ub_c == '0;
			ub_s1   <= ub_c;
			for (int ch = 0; ch < NCH; ch++) begin
				ua_s1[ch]    <= num_c[ch][NUM_W-1] ? UA_W'(-num_c[ch]) : UA_W'(num_c[ch]);
				neg_s1[ch]   <= num_c[ch][NUM_W-1] ^ lerp_in.den[acm_pkg::DY_W-1];
				start_s1[ch] <= start_c[ch];
			end

			zero_s2 <= zero_s1;
			d_s2    <= {ub_s1, 1'b0};
			for (int ch = 0; ch < NCH; ch++) begin
				n_s2[ch]     <= REM_W'({ua_s1[ch], 1'b0}) + REM_W'(ub_s1);
				neg_s2[ch]   <= neg_s1[ch];
				start_s2[ch] <= start_s1[ch];
			end

			zero_s[0] <= zero_s2;
			d_s[0]    <= d_s2;
			for (int ch = 0; ch < NCH; ch++) begin
				ovf_s[0][ch]   <= n_s2[ch] >= {d_s2, {Q_W{1'b0}}};
				rem_s[0][ch]   <= n_s2[ch];
				quo_s[0][ch]   <= '0;
				neg_s[0][ch]   <= neg_s2[ch];
				start_s[0][ch] <= start_s2[ch];
			end

			for (int j = 0; j < Q_W; j++) begin
				zero_s[j+1] <= zero_s[j];
				d_s[j+1]    <= d_s[j];
				for (int ch = 0; ch < NCH; ch++) begin
					rem_s[j+1][ch]   <= rem_nx[j][ch];
					quo_s[j+1][ch]   <= quo_nx[j][ch];
					ovf_s[j+1][ch]   <= ovf_s[j][ch];
					neg_s[j+1][ch]   <= neg_s[j][ch];
					start_s[j+1][ch] <= start_s[j][ch];
				end
			end

			color_s13 <= '{red: col_nx[0], green: col_nx[1], blue: col_nx[2]};
		end
	end

	assign valid = valid_s13;
	assign color = color_s13;

	// a zero divisor must always show up as overflow at the check stage
	a_zero_ovf: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s[0] && zero_s[0] |-> ovf_s[0][0] && ovf_s[0][1] && ovf_s[0][2])
		else $error("zero divisor not flagged as quotient overflow");

	// after the last quotient bit the remainder is below the divisor
	a_rem_bound: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s[Q_W] && !zero_s[Q_W] && !ovf_s[Q_W][0]
			|-> rem_s[Q_W][0] < REM_W'(d_s[Q_W]))
		else $error("divider remainder not reduced below divisor");

endmodule
